// ===== hw/rtl/ppu_pkg.sv =====
// ----------------------------------------------------------------------------
// ppu_pkg
// Shared types, constants and helpers of the particle pool update block.
// ----------------------------------------------------------------------------
`default_nettype none

package ppu_pkg;

	// Link value that marks the end of a list.
	localparam logic [6:0] LINK_NONE = 7'h7F;

	// Item codes.
	localparam logic [1:0] FUNC_SPAWN = 2'd0;
	localparam logic [1:0] FUNC_TICK  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR = 2'd2;

	// Register indexes on the configuration port.
	localparam logic [1:0] REG_GRAV_X = 2'd0;
	localparam logic [1:0] REG_GRAV_Y = 2'd1;
	localparam logic [1:0] REG_GRAV_Z = 2'd2;

	// Slot data that is written only when a particle is spawned.
	typedef struct packed {
		logic [15:0] life;
		logic [63:0] color_ends;
		logic [31:0] scale_ends;
		logic [31:0] angle_ends;
		logic [47:0] accel;
	} stat_t;

	// Slot data that every tick rewrites.
	typedef struct packed {
		logic [15:0] age;
		logic [47:0] vel;
		logic [47:0] pos;
	} dyn_t;

	localparam int STAT_W = $bits(stat_t);
	localparam int DYN_W  = $bits(dyn_t);

	// Signed 16-bit add that clips to the representable range.
	function automatic logic [15:0] sat_add16(input logic [15:0] a, input logic [15:0] b);
		logic [15:0] s;
		begin
			s = a + b;
			if (a[15] == b[15] && s[15] != a[15]) begin
				sat_add16 = a[15] ? 16'h8000 : 16'h7FFF;
			end else begin
				sat_add16 = s;
			end
		end
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/ppu_ram.sv =====
// ----------------------------------------------------------------------------
// ppu_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                             clk,
	input  wire logic                             we,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                 wdata,
	input  wire logic [(DEPTH>1?$clog2(DEPTH):1)-1:0] raddr,
	output logic      [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== hw/rtl/ppu_lerp.sv =====
// ----------------------------------------------------------------------------
// ppu_lerp
// Shared interpolation unit: lo + ((hi - lo) * age) / life, quotient
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ppu_lerp (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [16:0] lo,
	input  wire logic signed [16:0] hi,
	input  wire logic        [15:0] age,
	input  wire logic        [15:0] life,
	output logic                    done,
	output logic signed      [16:0] result
);

	typedef enum logic [2:0] {L_IDLE, L_MUL, L_ABS, L_DIV, L_FIN} lstate_t;

	lstate_t            state_q;
	logic signed [17:0] diff_q;
	logic signed [16:0] lo_q;
	logic        [15:0] age_q;
	logic        [15:0] life_q;
	logic signed [34:0] prod_q;
	logic               neg_q;
	logic        [15:0] rem_q;
	logic        [15:0] num_q;
	logic        [15:0] quo_q;
	logic        [3:0]  cnt_q;

	logic signed [34:0] prod;
	logic        [34:0] mag;
	logic        [16:0] trial;
	logic        [16:0] trial_sub;
	logic        [17:0] quo_s;

	assign prod      = diff_q * $signed({19'd0, age_q});
	assign mag       = prod_q[34] ? 35'(-prod_q) : prod_q;
	assign trial     = {rem_q, num_q[15]};
	assign trial_sub = trial - {1'b0, life_q};
	assign quo_s     = neg_q ? 18'(-{2'b00, quo_q}) : {2'b00, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= L_IDLE;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				L_IDLE: begin
					if (start) begin
						diff_q  <= 18'(hi) - 18'(lo);
						lo_q    <= lo;
						age_q   <= age;
						life_q  <= life;
						state_q <= L_MUL;
					end
				end
				L_MUL: begin
					prod_q  <= prod;
					state_q <= L_ABS;
				end
				L_ABS: begin
					// The magnitude is below life * 2^16, so the top half is a valid
					// starting remainder.
					neg_q   <= prod_q[34];
					rem_q   <= mag[31:16];
					num_q   <= mag[15:0];
					quo_q   <= '0;
					cnt_q   <= '0;
					state_q <= L_DIV;
				end
				L_DIV: begin
					if (!trial_sub[16]) begin
						rem_q <= trial_sub[15:0];
						quo_q <= {quo_q[14:0], 1'b1};
					end else begin
						rem_q <= trial[15:0];
						quo_q <= {quo_q[14:0], 1'b0};
					end
					num_q <= {num_q[14:0], 1'b0};
					cnt_q <= cnt_q + 4'd1;
					if (cnt_q == 4'd15) begin
						state_q <= L_FIN;
					end
				end
				L_FIN: begin
					result  <= 17'(18'(lo_q) + quo_s);
					done    <= 1'b1;
					state_q <= L_IDLE;
				end
				default: state_q <= L_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/particle_pool_update.sv =====
// ----------------------------------------------------------------------------
// particle_pool_update
// Particle pool with spawn, tick and clear items; one shared interpolation
// unit under a sequencer walks the live list.
// ----------------------------------------------------------------------------
//  Channel   Handshake             Payload
//  input     start, busy           func, life_frames, spawn_*, *_begin, *_final
//  result    sprite_valid strobe   sprite_position/angle/scale/color, last_sprite
//  config    APB psel/penable      gravity_x/y/z at byte 0, 4, 8
//
// A spawn into a pool with a free slot keeps busy high until the slot is
// written; a spawn into a full pool, clear, unused codes and a tick with no
// live particle keep it low. A tick walks the live list: a particle that
// survives is advanced and put through six interpolations in the shared
// divider, one that expires is unlinked onto the free list. No clearing pass
// follows reset. busy is high for the whole item; results cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module particle_pool_update #(
	parameter int POOL_SIZE = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [15:0] life_frames,
	input  wire logic [47:0] spawn_position,
	input  wire logic [47:0] spawn_velocity,
	input  wire logic [47:0] spawn_accel,
	input  wire logic signed [15:0] angle_begin,
	input  wire logic signed [15:0] angle_final,
	input  wire logic [15:0] scale_begin,
	input  wire logic [15:0] scale_final,
	input  wire logic [31:0] color_begin,
	input  wire logic [31:0] color_final,
	output logic             sprite_valid,
	output logic [47:0]      sprite_position,
	output logic signed [15:0] sprite_angle,
	output logic [15:0]      sprite_scale,
	output logic [31:0]      sprite_color,
	output logic             last_sprite,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready
);

	localparam int IW = (POOL_SIZE > 1) ? $clog2(POOL_SIZE) : 1;
	localparam logic [6:0] POOL_N = 7'(POOL_SIZE);

	typedef enum logic [3:0] {
		S_IDLE, S_SP_LINK, S_SP_WRITE, S_T_READ, S_T_EVAL, S_T_FREE1, S_T_FREE2,
		S_T_NEXT, S_ADV1, S_ADV2, S_ADV3, S_L_START, S_L_WAIT, S_T_EMIT, S_T_END
	} state_t;

	state_t      state_q;
	logic [15:0] grav_x_q, grav_y_q, grav_z_q;
	logic [6:0]  live_head_q, free_head_q, live_count_q, fresh_q;
	logic [6:0]  slot_q, cur_q, prev_q, nxt_q;

	ppu_pkg::stat_t sp_stat_q, stat_q;
	ppu_pkg::dyn_t  sp_dyn_q;
	logic [15:0] age_q;
	logic [47:0] vel_q, pos_q;
	logic [2:0]  k_q;
	logic [15:0] ang_r_q, scl_r_q;
	logic [31:0] col_r_q;
	logic        pend_q;
	logic [47:0] pend_pos_q;
	logic [15:0] pend_ang_q, pend_scl_q;
	logic [31:0] pend_col_q;

	// RAM ports.
	logic              link_we, stat_we, dyn_we;
	logic [IW-1:0]     link_wa, link_ra, dat_wa;
	logic [6:0]        link_wd, link_rd;
	ppu_pkg::stat_t    stat_wd, stat_rd;
	ppu_pkg::dyn_t     dyn_wd, dyn_rd;

	logic [16:0] age_inc;
	logic        cfg_wr;
	logic        lerp_start, lerp_done;
	logic signed [16:0] lerp_lo, lerp_hi, lerp_res;
	logic [47:0] gvec;

	assign busy    = (state_q != S_IDLE);
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign age_inc = {1'b0, dyn_rd.age} + 17'd1;
	assign gvec    = {grav_z_q, grav_y_q, grav_x_q};

	always_comb begin
		case (paddr[3:2])
			ppu_pkg::REG_GRAV_X: prdata = {16'd0, grav_x_q};
			ppu_pkg::REG_GRAV_Y: prdata = {16'd0, grav_y_q};
			ppu_pkg::REG_GRAV_Z: prdata = {16'd0, grav_z_q};
			default:             prdata = 32'd0;
		endcase
	end

	// RAM control follows the sequencer state.
	always_comb begin
		link_we = 1'b0;
		link_wa = cur_q[IW-1:0];
		link_wd = free_head_q;
		stat_we = 1'b0;
		dyn_we  = 1'b0;
		dat_wa  = cur_q[IW-1:0];
		stat_wd = sp_stat_q;
		dyn_wd  = sp_dyn_q;
		link_ra = (state_q == S_IDLE) ? free_head_q[IW-1:0] : cur_q[IW-1:0];
		case (state_q)
			S_SP_WRITE: begin
				link_we = 1'b1;
				link_wa = slot_q[IW-1:0];
				link_wd = live_head_q;
				stat_we = 1'b1;
				dyn_we  = 1'b1;
				dat_wa  = slot_q[IW-1:0];
			end
			S_T_FREE1: link_we = 1'b1;
			S_T_FREE2: begin
				link_we = 1'b1;
				link_wa = prev_q[IW-1:0];
				link_wd = nxt_q;
			end
			S_T_EMIT: begin
				dyn_we = 1'b1;
				dyn_wd = '{age: age_q, vel: vel_q, pos: pos_q};
			end
			default: ;
		endcase
	end

	// Operand select for the shared interpolation unit.
	always_comb begin
		case (k_q)
			3'd0: begin
				lerp_lo = 17'(signed'(stat_q.angle_ends[15:0]));
				lerp_hi = 17'(signed'(stat_q.angle_ends[31:16]));
			end
			3'd1: begin
				lerp_lo = {1'b0, stat_q.scale_ends[15:0]};
				lerp_hi = {1'b0, stat_q.scale_ends[31:16]};
			end
			3'd2: begin
				lerp_lo = {9'd0, stat_q.color_ends[7:0]};
				lerp_hi = {9'd0, stat_q.color_ends[39:32]};
			end
			3'd3: begin
				lerp_lo = {9'd0, stat_q.color_ends[15:8]};
				lerp_hi = {9'd0, stat_q.color_ends[47:40]};
			end
			3'd4: begin
				lerp_lo = {9'd0, stat_q.color_ends[23:16]};
				lerp_hi = {9'd0, stat_q.color_ends[55:48]};
			end
			default: begin
				lerp_lo = {9'd0, stat_q.color_ends[31:24]};
				lerp_hi = {9'd0, stat_q.color_ends[63:56]};
			end
		endcase
	end

	assign lerp_start = (state_q == S_L_START);

	ppu_ram #(.WIDTH(7), .DEPTH(POOL_SIZE)) u_link_ram (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(link_ra), .rdata(link_rd)
	);

	ppu_ram #(.WIDTH(ppu_pkg::STAT_W), .DEPTH(POOL_SIZE)) u_stat_ram (
		.clk(clk), .we(stat_we), .waddr(dat_wa), .wdata(stat_wd),
		.raddr(cur_q[IW-1:0]), .rdata(stat_rd)
	);

	ppu_ram #(.WIDTH(ppu_pkg::DYN_W), .DEPTH(POOL_SIZE)) u_dyn_ram (
		.clk(clk), .we(dyn_we), .waddr(dat_wa), .wdata(dyn_wd),
		.raddr(cur_q[IW-1:0]), .rdata(dyn_rd)
	);

	ppu_lerp u_lerp (
		.clk(clk), .arst_n(arst_n), .start(lerp_start),
		.lo(lerp_lo), .hi(lerp_hi), .age(age_q), .life(stat_q.life),
		.done(lerp_done), .result(lerp_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			grav_x_q     <= '0;
			grav_y_q     <= '0;
			grav_z_q     <= '0;
			live_head_q  <= ppu_pkg::LINK_NONE;
			free_head_q  <= ppu_pkg::LINK_NONE;
			live_count_q <= '0;
			fresh_q      <= '0;
			pend_q       <= 1'b0;
			sprite_valid <= 1'b0;
		end else begin
			sprite_valid <= 1'b0;
			if (cfg_wr) begin
				case (paddr[3:2])
					ppu_pkg::REG_GRAV_X: grav_x_q <= pwdata[15:0];
					ppu_pkg::REG_GRAV_Y: grav_y_q <= pwdata[15:0];
					ppu_pkg::REG_GRAV_Z: grav_z_q <= pwdata[15:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (start) begin
						case (func)
							ppu_pkg::FUNC_SPAWN: begin
								sp_stat_q <= '{life: life_frames,
									color_ends: {color_final, color_begin},
									scale_ends: {scale_final, scale_begin},
									angle_ends: {angle_final, angle_begin},
									accel: spawn_accel};
								sp_dyn_q <= '{age: 16'd0, vel: spawn_velocity,
									pos: spawn_position};
								if (live_count_q < POOL_N) begin
									// Recycled slots come first; untouched slots sit
									// above the fresh mark.
									if (free_head_q < POOL_N) begin
										slot_q  <= free_head_q;
										state_q <= S_SP_LINK;
									end else begin
										slot_q  <= fresh_q;
										fresh_q <= fresh_q + 7'd1;
										state_q <= S_SP_WRITE;
									end
								end
							end
							ppu_pkg::FUNC_TICK: begin
								cur_q  <= live_head_q;
								prev_q <= ppu_pkg::LINK_NONE;
								pend_q <= 1'b0;
								if (live_head_q < POOL_N) begin
									state_q <= S_T_READ;
								end
							end
							ppu_pkg::FUNC_CLEAR: begin
								live_head_q  <= ppu_pkg::LINK_NONE;
								free_head_q  <= ppu_pkg::LINK_NONE;
								live_count_q <= '0;
								fresh_q      <= '0;
							end
							default: ;
						endcase
					end
				end
				S_SP_LINK: begin
					free_head_q <= link_rd;
					state_q     <= S_SP_WRITE;
				end
				S_SP_WRITE: begin
					live_head_q     <= slot_q;
					live_count_q    <= live_count_q + 7'd1;
					sprite_valid    <= 1'b1;
					sprite_position <= sp_dyn_q.pos;
					sprite_angle    <= sp_stat_q.angle_ends[15:0];
					sprite_scale    <= sp_stat_q.scale_ends[15:0];
					sprite_color    <= sp_stat_q.color_ends[31:0];
					last_sprite     <= 1'b1;
					state_q         <= S_IDLE;
				end
				S_T_READ: state_q <= S_T_EVAL;
				S_T_EVAL: begin
					nxt_q  <= link_rd;
					stat_q <= stat_rd;
					age_q  <= age_inc[15:0];
					vel_q  <= dyn_rd.vel;
					pos_q  <= dyn_rd.pos;
					if (age_inc > {1'b0, stat_rd.life}) begin
						state_q <= S_T_FREE1;
					end else begin
						state_q <= S_ADV1;
					end
				end
				S_T_FREE1: begin
					free_head_q  <= cur_q;
					live_count_q <= live_count_q - 7'd1;
					if (prev_q == ppu_pkg::LINK_NONE) begin
						live_head_q <= nxt_q;
						state_q     <= S_T_NEXT;
					end else begin
						state_q <= S_T_FREE2;
					end
				end
				S_T_FREE2: state_q <= S_T_NEXT;
				S_T_NEXT: begin
					cur_q <= nxt_q;
					if (nxt_q < POOL_N) begin
						state_q <= S_T_READ;
					end else begin
						state_q <= S_T_END;
					end
				end
				S_ADV1: begin
					for (int l = 0; l < 3; l++) begin
						vel_q[16*l +: 16] <= ppu_pkg::sat_add16(vel_q[16*l +: 16],
							stat_q.accel[16*l +: 16]);
					end
					state_q <= S_ADV2;
				end
				S_ADV2: begin
					for (int l = 0; l < 3; l++) begin
						vel_q[16*l +: 16] <= ppu_pkg::sat_add16(vel_q[16*l +: 16],
							gvec[16*l +: 16]);
					end
					state_q <= S_ADV3;
				end
				S_ADV3: begin
					for (int l = 0; l < 3; l++) begin
						pos_q[16*l +: 16] <= ppu_pkg::sat_add16(pos_q[16*l +: 16],
							vel_q[16*l +: 16]);
					end
					k_q     <= '0;
					state_q <= S_L_START;
				end
				S_L_START: state_q <= S_L_WAIT;
				S_L_WAIT: begin
					if (lerp_done) begin
						case (k_q)
							3'd0:    ang_r_q <= lerp_res[15:0];
							3'd1:    scl_r_q <= lerp_res[15:0];
							3'd2:    col_r_q[7:0]   <= lerp_res[7:0];
							3'd3:    col_r_q[15:8]  <= lerp_res[7:0];
							3'd4:    col_r_q[23:16] <= lerp_res[7:0];
							default: col_r_q[31:24] <= lerp_res[7:0];
						endcase
						k_q <= k_q + 3'd1;
						if (k_q == 3'd5) begin
							state_q <= S_T_EMIT;
						end else begin
							state_q <= S_L_START;
						end
					end
				end
				S_T_EMIT: begin
					// A sprite is held back one particle so the last one of the run
					// can be marked.
					if (pend_q) begin
						sprite_valid    <= 1'b1;
						sprite_position <= pend_pos_q;
						sprite_angle    <= pend_ang_q;
						sprite_scale    <= pend_scl_q;
						sprite_color    <= pend_col_q;
						last_sprite     <= 1'b0;
					end
					pend_q     <= 1'b1;
					pend_pos_q <= pos_q;
					pend_ang_q <= ang_r_q;
					pend_scl_q <= scl_r_q;
					pend_col_q <= col_r_q;
					prev_q     <= cur_q;
					state_q    <= S_T_NEXT;
				end
				S_T_END: begin
					if (pend_q) begin
						sprite_valid    <= 1'b1;
						sprite_position <= pend_pos_q;
						sprite_angle    <= pend_ang_q;
						sprite_scale    <= pend_scl_q;
						sprite_color    <= pend_col_q;
						last_sprite     <= 1'b1;
					end
					pend_q  <= 1'b0;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire
